// ===== rtl/hfr_pkg.sv =====
// Shared types and constants for the frame receiver.
// Used by every module under rtl; depends on nothing.
package hfr_pkg;

  localparam int MAX_ADDR_BYTES = 4;
  localparam logic [2:0] ADDR_BYTES_MAX = 3'(MAX_ADDR_BYTES);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [11:0] CNT_MAX = 12'hFFF;

  // Result tags
  localparam logic [3:0] TAG_INFO    = 4'd0;
  localparam logic [3:0] TAG_STATUS  = 4'd1;
  localparam logic [3:0] TAG_TYPE    = 4'd2;
  localparam logic [3:0] TAG_SEG     = 4'd3;
  localparam logic [3:0] TAG_LENGTH  = 4'd4;
  localparam logic [3:0] TAG_DST     = 4'd5;
  localparam logic [3:0] TAG_DSTLEN  = 4'd6;
  localparam logic [3:0] TAG_SRC     = 4'd7;
  localparam logic [3:0] TAG_SRCLEN  = 4'd8;
  localparam logic [3:0] TAG_CTL     = 4'd9;
  localparam logic [3:0] TAG_NR      = 4'd10;
  localparam logic [3:0] TAG_NS      = 4'd11;
  localparam logic [3:0] TAG_PF      = 4'd12;
  localparam logic [3:0] TAG_HCS     = 4'd13;
  localparam logic [3:0] TAG_FCS     = 4'd14;
  localparam logic [3:0] TAG_INFOLEN = 4'd15;

  // End report status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_DST   = 3'd3;
  localparam logic [2:0] ST_SRC   = 3'd4;
  localparam logic [2:0] ST_CTL   = 3'd5;
  localparam logic [2:0] ST_HCS   = 3'd6;
  localparam logic [2:0] ST_INFO  = 3'd7;

  // Low nibble of the supervisory frames that carry nr
  localparam logic [3:0] CTL_RR  = 4'h1;
  localparam logic [3:0] CTL_RNR = 4'h5;

  typedef struct packed {
    logic [3:0]  tag;
    logic [27:0] value;
    logic        last;
  } result_t;

  // Header fields captured at the closing flag
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  ftype;
    logic        seg;
    logic [10:0] length;
    logic [27:0] dst;
    logic [2:0]  dst_len;
    logic [27:0] src;
    logic [2:0]  src_len;
    logic [7:0]  ctl;
    logic [2:0]  nr;
    logic [2:0]  ns;
    logic        pf;
    logic [15:0] hcs;
    logic [15:0] fcs;
    logic [11:0] info_len;
  } snap_t;

endpackage

// ===== rtl/hdlc_frame_receiver.sv =====
// Top level of the HDLC type 3 frame receiver.
// Depends on hfr_pkg, hfr_parser, hfr_report and hfr_out_buf.
//
//   channel  ports                                     request
//   -------  ----------------------------------------  ---------------------------
//   in       in_valid, in_stall, in_rx_byte            one received line byte
//   out      out_valid, out_stall, out_field_tag,      one info byte or one tagged
//            out_field_value, out_last_of_frame        field of an end report
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle is taken
// while no end report runs and the output register and its skid stage have room.
// A closing flag after a non-empty frame starts a 15-request end report; input
// holds stall while the report runs, which lasts longer if out_stall is high.
// in_stall is also high while the skid stage is occupied.
// rst_n is synchronous, active low; after reset bytes are dropped until a flag.
module hdlc_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_field_tag,
  output logic [27:0] out_field_value,
  output logic        out_last_of_frame
);

  logic             take;
  logic             info_push;
  hfr_pkg::result_t info_res;
  logic             rpt_start;
  hfr_pkg::snap_t   snap;
  logic             rpt_push;
  hfr_pkg::result_t rpt_res;
  logic             rpt_busy;
  logic             buf_full;
  logic             push;
  hfr_pkg::result_t push_res;
  hfr_pkg::result_t out_res;

  // Hold input while a report is running or the skid stage is occupied
  assign in_stall = rpt_busy || buf_full;
  assign take     = in_valid && !in_stall;

  hfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .info_push (info_push),
    .info_res  (info_res),
    .rpt_start (rpt_start),
    .snap      (snap)
  );

  hfr_report u_report (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rpt_start),
    .snap  (snap),
    .ready (!buf_full),
    .push  (rpt_push),
    .res   (rpt_res),
    .busy  (rpt_busy)
  );

  // Info bytes only come while no report runs, so the two never collide
  assign push     = info_push || rpt_push;
  assign push_res = rpt_push ? rpt_res : info_res;

  hfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_field_tag     = out_res.tag;
  assign out_field_value   = out_res.value;
  assign out_last_of_frame = out_res.last;

  // Skid stage only fills behind a held output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid stage occupied with empty output register");

  // Frame end marker only on the infolen field
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame) |-> (out_field_tag == hfr_pkg::TAG_INFOLEN))
    else $error("last_of_frame on a field other than infolen");

  // Report ends right after its final field is pushed
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (rpt_push && rpt_res.last) |=> !rpt_busy)
    else $error("report still busy after final field");

  // Parser never pushes an info byte or starts a report while one runs
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rpt_busy |-> !(info_push || rpt_start))
    else $error("parser activity during end report");

endmodule

// ===== rtl/hfr_parser.sv =====
// Frame parser: per-byte header state, info holdback and report snapshot.
// Depends on hfr_pkg.
module hfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output logic            info_push,
  output hfr_pkg::result_t info_res,
  output logic            rpt_start,
  output hfr_pkg::snap_t  snap
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_DST  = 3'd2;
  localparam logic [2:0] PH_SRC  = 3'd3;
  localparam logic [2:0] PH_CTL  = 3'd4;
  localparam logic [2:0] PH_HCS  = 3'd5;
  localparam logic [2:0] PH_INFO = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic        sub_r, sub_nxt;
  logic [3:0]  type_r, type_nxt;
  logic        seg_r, seg_nxt;
  logic [10:0] len_r, len_nxt;
  logic [27:0] dst_r, dst_nxt;
  logic [2:0]  dstn_r, dstn_nxt;
  logic [27:0] src_r, src_nxt;
  logic [2:0]  srcn_r, srcn_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [15:0] hcs_r, hcs_nxt;
  logic [11:0] icnt_r, icnt_nxt;
  logic [11:0] bcnt_r, bcnt_nxt;
  logic [7:0]  hold0_r, hold1_r;

  logic is_flag, hunting, data_byte, info_byte;

  assign is_flag   = (rx_byte == hfr_pkg::FLAG_BYTE);
  assign hunting   = (phase_r == PH_HUNT) || (phase_r > PH_INFO);
  assign data_byte = take && !hunting && !is_flag;
  assign info_byte = data_byte && (phase_r == PH_INFO);

  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    type_nxt  = type_r;
    seg_nxt   = seg_r;
    len_nxt   = len_r;
    dst_nxt   = dst_r;
    dstn_nxt  = dstn_r;
    src_nxt   = src_r;
    srcn_nxt  = srcn_r;
    ctl_nxt   = ctl_r;
    hcs_nxt   = hcs_r;
    icnt_nxt  = icnt_r;
    bcnt_nxt  = bcnt_r;
    if (take && is_flag) begin
      // open a frame
      phase_nxt = PH_TYPE;
      sub_nxt   = 1'b0;
      type_nxt  = '0;
      seg_nxt   = 1'b0;
      len_nxt   = '0;
      dst_nxt   = '0;
      dstn_nxt  = '0;
      src_nxt   = '0;
      srcn_nxt  = '0;
      ctl_nxt   = '0;
      hcs_nxt   = '0;
      icnt_nxt  = '0;
      bcnt_nxt  = '0;
    end else if (data_byte) begin
      if (bcnt_r != hfr_pkg::CNT_MAX) begin
        bcnt_nxt = bcnt_r + 12'd1;
      end
      unique case (phase_r)
        PH_TYPE: begin
          if (!sub_r) begin
            type_nxt = rx_byte[7:4];
            seg_nxt  = rx_byte[3];
            len_nxt  = {rx_byte[2:0], 8'h00};
            sub_nxt  = 1'b1;
          end else begin
            len_nxt   = {len_r[10:8], rx_byte};
            sub_nxt   = 1'b0;
            phase_nxt = PH_DST;
          end
        end
        PH_DST: begin
          if (dstn_r < hfr_pkg::ADDR_BYTES_MAX) begin
            dst_nxt  = {dst_r[20:0], rx_byte[7:1]};
            dstn_nxt = dstn_r + 3'd1;
            if (rx_byte[0]) begin
              phase_nxt = PH_SRC;
            end
          end
        end
        PH_SRC: begin
          if (srcn_r < hfr_pkg::ADDR_BYTES_MAX) begin
            src_nxt  = {src_r[20:0], rx_byte[7:1]};
            srcn_nxt = srcn_r + 3'd1;
            if (rx_byte[0]) begin
              phase_nxt = PH_CTL;
            end
          end
        end
        PH_CTL: begin
          ctl_nxt   = rx_byte;
          sub_nxt   = 1'b0;
          phase_nxt = PH_HCS;
        end
        PH_HCS: begin
          if (!sub_r) begin
            hcs_nxt = {rx_byte, 8'h00};
            sub_nxt = 1'b1;
          end else begin
            hcs_nxt   = {hcs_r[15:8], rx_byte};
            sub_nxt   = 1'b0;
            phase_nxt = PH_INFO;
          end
        end
        default: begin
          if (icnt_r != hfr_pkg::CNT_MAX) begin
            icnt_nxt = icnt_r + 12'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sub_r   <= 1'b0;
      type_r  <= '0;
      seg_r   <= 1'b0;
      len_r   <= '0;
      dst_r   <= '0;
      dstn_r  <= '0;
      src_r   <= '0;
      srcn_r  <= '0;
      ctl_r   <= '0;
      hcs_r   <= '0;
      icnt_r  <= '0;
      bcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      type_r  <= type_nxt;
      seg_r   <= seg_nxt;
      len_r   <= len_nxt;
      dst_r   <= dst_nxt;
      dstn_r  <= dstn_nxt;
      src_r   <= src_nxt;
      srcn_r  <= srcn_nxt;
      ctl_r   <= ctl_nxt;
      hcs_r   <= hcs_nxt;
      icnt_r  <= icnt_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  // Two-byte holdback; entries are read only after being written in the frame
  always_ff @(posedge clk) begin
    if (info_byte) begin
      hold0_r <= hold1_r;
      hold1_r <= rx_byte;
    end
  end

  assign info_push      = info_byte && (icnt_r >= 12'd2);
  assign info_res.tag   = hfr_pkg::TAG_INFO;
  assign info_res.value = {20'd0, hold0_r};
  assign info_res.last  = 1'b0;

  assign rpt_start = take && !hunting && is_flag && (bcnt_r != 12'd0);

  always_comb begin
    snap.ftype   = type_r;
    snap.seg     = seg_r;
    snap.length  = len_r;
    snap.dst     = dst_r;
    snap.dst_len = dstn_r;
    snap.src     = src_r;
    snap.src_len = srcn_r;
    snap.ctl     = ctl_r;
    snap.hcs     = hcs_r;
    snap.pf      = ctl_r[4];

    if (bcnt_r != {1'b0, len_r}) begin
      snap.status = hfr_pkg::ST_LEN;
    end else if (phase_r == PH_TYPE || (phase_r == PH_DST && dstn_r == 3'd0)) begin
      snap.status = hfr_pkg::ST_TYPE;
    end else if (phase_r == PH_DST) begin
      snap.status = hfr_pkg::ST_DST;
    end else if (phase_r == PH_SRC) begin
      snap.status = hfr_pkg::ST_SRC;
    end else if (phase_r == PH_CTL) begin
      snap.status = hfr_pkg::ST_CTL;
    end else if (phase_r == PH_HCS) begin
      snap.status = hfr_pkg::ST_HCS;
    end else if (icnt_r == 12'd1 || icnt_r == 12'd2) begin
      snap.status = hfr_pkg::ST_INFO;
    end else begin
      snap.status = hfr_pkg::ST_OK;
    end

    if (phase_r == PH_INFO && icnt_r > 12'd2) begin
      snap.info_len = icnt_r - 12'd2;
      snap.fcs      = {hold0_r, hold1_r};
    end else begin
      snap.info_len = '0;
      snap.fcs      = '0;
    end

    if (!ctl_r[0]) begin
      snap.nr = ctl_r[7:5];
      snap.ns = ctl_r[3:1];
    end else begin
      snap.ns = 3'd0;
      // only RR and RNR supervisory frames carry nr
      if (ctl_r[3:0] == hfr_pkg::CTL_RR || ctl_r[3:0] == hfr_pkg::CTL_RNR) begin
        snap.nr = ctl_r[7:5];
      end else begin
        snap.nr = 3'd0;
      end
    end
  end

endmodule

// ===== rtl/hfr_report.sv =====
// End-of-frame report sequencer: holds the captured header and walks its tags.
// Depends on hfr_pkg.
module hfr_report (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  hfr_pkg::snap_t   snap,
  input  logic             ready,
  output logic             push,
  output hfr_pkg::result_t res,
  output logic             busy
);

  hfr_pkg::snap_t snap_r;
  logic           busy_r;
  logic [3:0]     tag_r;

  assign busy    = busy_r;
  assign push    = busy_r && ready;
  assign res.tag = tag_r;
  assign res.last = (tag_r == hfr_pkg::TAG_INFOLEN);

  always_comb begin
    unique case (tag_r)
      hfr_pkg::TAG_STATUS:  res.value = {25'd0, snap_r.status};
      hfr_pkg::TAG_TYPE:    res.value = {24'd0, snap_r.ftype};
      hfr_pkg::TAG_SEG:     res.value = {27'd0, snap_r.seg};
      hfr_pkg::TAG_LENGTH:  res.value = {17'd0, snap_r.length};
      hfr_pkg::TAG_DST:     res.value = snap_r.dst;
      hfr_pkg::TAG_DSTLEN:  res.value = {25'd0, snap_r.dst_len};
      hfr_pkg::TAG_SRC:     res.value = snap_r.src;
      hfr_pkg::TAG_SRCLEN:  res.value = {25'd0, snap_r.src_len};
      hfr_pkg::TAG_CTL:     res.value = {20'd0, snap_r.ctl};
      hfr_pkg::TAG_NR:      res.value = {25'd0, snap_r.nr};
      hfr_pkg::TAG_NS:      res.value = {25'd0, snap_r.ns};
      hfr_pkg::TAG_PF:      res.value = {27'd0, snap_r.pf};
      hfr_pkg::TAG_HCS:     res.value = {12'd0, snap_r.hcs};
      hfr_pkg::TAG_FCS:     res.value = {12'd0, snap_r.fcs};
      hfr_pkg::TAG_INFOLEN: res.value = {16'd0, snap_r.info_len};
      default:              res.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tag_r  <= hfr_pkg::TAG_STATUS;
    end else if (start) begin
      busy_r <= 1'b1;
      tag_r  <= hfr_pkg::TAG_STATUS;
    end else if (push) begin
      if (tag_r == hfr_pkg::TAG_INFOLEN) begin
        busy_r <= 1'b0;
      end else begin
        tag_r <= tag_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      snap_r <= snap;
    end
  end

endmodule

// ===== rtl/hfr_out_buf.sv =====
// Result output register with a skid stage.
// Depends on hfr_pkg.
module hfr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hfr_pkg::result_t push_res,
  input  logic             out_stall,
  output logic             out_valid,
  output hfr_pkg::result_t out_res,
  output logic             full
);

  hfr_pkg::result_t main_r, skid_r;
  logic             main_vld_r, skid_vld_r;
  logic             pop;

  assign pop       = main_vld_r && !out_stall;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;
  assign full      = skid_vld_r;

  // push is only offered while the skid stage is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= push_res;
      end else begin
        skid_r <= push_res;
      end
    end else if (pop && skid_vld_r) begin
      main_r <= skid_r;
    end
  end

endmodule
